[sv/lsnd_pkg.sv]
// Shared types and constants for the LZ4 sequence nibble decryptor.
package lsnd_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [3:0] NIBBLE_ALL = 4'hF;
  localparam logic [7:0] BYTE_ALL   = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] REG_SUBST  = 2'd0;
  localparam logic [1:0] REG_KEY_LO = 2'd1;
  localparam logic [1:0] REG_KEY_HI = 2'd2;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LIT_EXT,
    PH_LITERAL,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MAT_EXT
  } phase_t;

  typedef struct packed {
    logic [63:0] subst;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
  } cipher_cfg_t;

endpackage

[sv/lsnd_keyer.sv]
// Byte unscrambler: substituted nibbles minus a key from four key table entries.
module lsnd_keyer
  import lsnd_pkg::*;
(
  input  cipher_cfg_t cfg,
  input  logic [7:0]  key_index,
  input  logic [7:0]  din,
  output logic [7:0]  dout
);

  logic [127:0] key_table;
  logic [3:0]   sel_a, sel_b, sel_c, sel_d;
  logic [7:0]   key_byte;
  logic [3:0]   sub_lo, sub_hi;

  assign key_table = {cfg.key_hi, cfg.key_lo};

  assign sel_a = {2'b01, key_index[3:2]};
  assign sel_b = {2'b00, key_index[1:0]};
  assign sel_c = {2'b10, key_index[5:4]};
  assign sel_d = {2'b11, key_index[7:6]};

  // 8-bit wraparound sum of the four picked entries
  assign key_byte = key_table[{sel_a, 3'b000} +: 8] + key_table[{sel_b, 3'b000} +: 8]
                  + key_table[{sel_c, 3'b000} +: 8] + key_table[{sel_d, 3'b000} +: 8];

  assign sub_lo = cfg.subst[{din[3:0], 2'b00} +: 4];
  assign sub_hi = cfg.subst[{din[7:4], 2'b00} +: 4];

  assign dout = {sub_hi - key_byte[3:0], sub_lo - key_byte[3:0]};

endmodule

[sv/lz4_sequence_nibble_decryptor_unit.sv]
// Top level of the LZ4 sequence nibble decryptor.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------
//  in      | in_valid / in_ready    | data_byte, block_first, key_base
//  out     | out_valid / out_ready  | out_byte, was_decrypted
//  cfg     | cfg_valid / cfg_ready  | cfg_index (2 bits), cfg_data (64 bits)
//
// One byte per cycle sustained while out_ready stays high: a transfer lands in the
// input register, then the walk logic and the unscrambler produce the result into
// the output register and raise out_valid. The walk state (phase, literal count,
// key indexes) updates in that same cycle, which is what closes the feedback loop
// between consecutive bytes.
// Reset clears the walk to "expect token", key indexes to zero and all
// configuration registers to zero. A stalled output holds the result and the
// input register; in_ready drops only while both are full and out_ready is low.
// cfg_ready is always high; writes to index 3 are dropped.
module lz4_sequence_nibble_decryptor_unit
  import lsnd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        block_first,
  input  logic [7:0]  key_base,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        was_decrypted,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cipher_cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SUBST:  cfg.subst  <= cfg_data;
        REG_KEY_LO: cfg.key_lo <= cfg_data;
        REG_KEY_HI: cfg.key_hi <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_held;
  logic [7:0] byte_q;
  logic       first_q;
  logic [7:0] base_q;
  logic       advance;

  // Process the held byte whenever the output register is free or draining
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q  <= data_byte;
      first_q <= block_first;
      base_q  <= key_base;
    end
  end

  // ---------------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------------
  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] lit_left, lit_left_next;
  logic                   match_ext, match_ext_next;
  logic [7:0]             byte_idx, byte_idx_next;
  logic [7:0]             seq_idx, seq_idx_next;

  // Effective state after a block start drops the walk in progress
  phase_t                 phase_e;
  logic [COUNT_WIDTH-1:0] lit_e;
  logic                   match_e;
  logic [7:0]             seq_e;

  logic [7:0]             key_index;
  logic [7:0]             dec_byte;
  logic [COUNT_WIDTH:0]   lit_sum;
  logic [COUNT_WIDTH-1:0] lit_sat;
  logic [COUNT_WIDTH-1:0] lit_dec;
  logic [7:0]             res_byte;
  logic                   res_dec;

  assign phase_e = first_q ? PH_TOKEN : phase;
  assign lit_e   = first_q ? '0 : lit_left;
  assign match_e = first_q ? 1'b0 : match_ext;
  assign seq_e   = first_q ? base_q : seq_idx;

  // A token restarts the byte index at the sequence index
  assign key_index = (phase_e == PH_TOKEN) ? seq_e : byte_idx;

  lsnd_keyer u_keyer (
    .cfg       (cfg),
    .key_index (key_index),
    .din       (byte_q),
    .dout      (dec_byte)
  );

  // Saturating add of a length extension byte
  assign lit_sum = {1'b0, lit_e} + {{(COUNT_WIDTH-7){1'b0}}, dec_byte};
  assign lit_sat = lit_sum[COUNT_WIDTH] ? COUNT_MAX : lit_sum[COUNT_WIDTH-1:0];

  // Literal countdown never goes below zero
  assign lit_dec = (lit_e != '0) ? lit_e - 1'b1 : lit_e;

  always_comb begin
    phase_next     = phase_e;
    lit_left_next  = lit_e;
    match_ext_next = match_e;
    seq_idx_next   = seq_e;
    byte_idx_next  = key_index + 8'd1;
    res_byte       = dec_byte;
    res_dec        = 1'b1;

    unique case (phase_e)
      PH_TOKEN: begin
        seq_idx_next   = seq_e + 8'd1;
        lit_left_next  = {{(COUNT_WIDTH-4){1'b0}}, dec_byte[7:4]};
        match_ext_next = (dec_byte[3:0] == NIBBLE_ALL);
        if (dec_byte[7:4] == NIBBLE_ALL) begin
          phase_next = PH_LIT_EXT;
        end else if (dec_byte[7:4] != 4'd0) begin
          phase_next = PH_LITERAL;
        end else begin
          phase_next = PH_OFF_LO;
        end
      end
      PH_LIT_EXT: begin
        lit_left_next = lit_sat;
        if (dec_byte != BYTE_ALL) begin
          phase_next = (lit_sat != '0) ? PH_LITERAL : PH_OFF_LO;
        end
      end
      PH_LITERAL: begin
        res_byte      = byte_q;
        res_dec       = 1'b0;
        byte_idx_next = byte_idx;
        lit_left_next = lit_dec;
        if (lit_dec == '0) begin
          phase_next = PH_OFF_LO;
        end
      end
      PH_OFF_LO: begin
        phase_next = PH_OFF_HI;
      end
      PH_OFF_HI: begin
        phase_next = match_e ? PH_MAT_EXT : PH_TOKEN;
      end
      default: begin
        // Match length extension: a byte other than 0xFF ends the sequence
        if (dec_byte != BYTE_ALL) begin
          phase_next = PH_TOKEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TOKEN;
      lit_left  <= '0;
      match_ext <= 1'b0;
      byte_idx  <= '0;
      seq_idx   <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      lit_left  <= lit_left_next;
      match_ext <= match_ext_next;
      byte_idx  <= byte_idx_next;
      seq_idx   <= seq_idx_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte      <= res_byte;
      was_decrypted <= res_dec;
    end
  end

endmodule

[sv/lsnd_checker.sv]
// Port-level assertions for the decryptor top level, attached by bind.
module lsnd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       was_decrypted,
  input logic       cfg_ready
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(was_decrypted))
    else $error("stalled result changed");

  // With the output empty the input side can never be blocked
  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low while output register empty");

  // A draining output always frees room for a new byte
  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready && cfg_ready)
    else $error("in_ready low while output drains");

endmodule

bind lz4_sequence_nibble_decryptor_unit lsnd_checker u_lsnd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .was_decrypted (was_decrypted),
  .cfg_ready     (cfg_ready)
);
